// File: rtl/fcp_pkg.sv
// FCP template parser: shared types, phase codes, tag and length tables.
// No dependencies; used by every file of the block except fcp_if.
package fcp_pkg;

   localparam int QDepth = 4;
   localparam int QAw    = $clog2(QDepth);

   localparam logic [2:0] PH_OUTER_TAG = 3'd0;
   localparam logic [2:0] PH_OUTER_LEN = 3'd1;
   localparam logic [2:0] PH_TAG       = 3'd2;
   localparam logic [2:0] PH_LEN       = 3'd3;
   localparam logic [2:0] PH_VALUE     = 3'd4;

   localparam logic [7:0] TEMPLATE_TAG = 8'h62;
   localparam logic [7:0] TAG_SIZE     = 8'h80;
   localparam logic [7:0] TAG_DESC     = 8'h82;
   localparam logic [7:0] TAG_FILE_ID  = 8'h83;
   localparam logic [7:0] TAG_APP_ID   = 8'h84;
   localparam logic [7:0] TAG_SHORT_ID = 8'h88;
   localparam logic [7:0] TAG_LIFE     = 8'h8A;
   localparam logic [7:0] TAG_SEC      = 8'h8C;
   localparam logic [7:0] TAG_SEC_ENV  = 8'h8D;

   localparam logic [2:0] FID_SIZE     = 3'd0;
   localparam logic [2:0] FID_DESC     = 3'd1;
   localparam logic [2:0] FID_FILE_ID  = 3'd2;
   localparam logic [2:0] FID_APP_ID   = 3'd3;
   localparam logic [2:0] FID_SHORT_ID = 3'd4;
   localparam logic [2:0] FID_LIFE     = 3'd5;
   localparam logic [2:0] FID_SEC      = 3'd6;
   localparam logic [2:0] FID_SEC_ENV  = 3'd7;

   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;
   localparam logic ST_OK       = 1'b0;
   localparam logic ST_BAD_DATA = 1'b1;

   // length limit per field id, and whether it must match exactly
   localparam logic [4:0] FIELD_LIMIT [8] = '{5'd2, 5'd5, 5'd2, 5'd16, 5'd1, 5'd1, 5'd7, 5'd2};
   localparam logic [7:0] FIELD_EXACT = 8'b1011_0101;  // bit = field id

   typedef struct packed {
      logic       known;
      logic [2:0] fid;
   } fcp_tag_info_type;

   typedef struct packed {
      logic       has_value;
      logic [2:0] field_id;
      logic [3:0] byte_index;
      logic [7:0] value_byte;
      logic       has_status;
      logic       status;
   } fcp_entry_type;

   typedef struct packed {
      logic       kind;
      logic [2:0] field_id;
      logic [3:0] byte_index;
      logic [7:0] value_byte;
      logic       status;
      logic       end_of_run;
   } fcp_result_type;

   function automatic fcp_tag_info_type tag_lookup(input logic [7:0] tag);
      fcp_tag_info_type info;
      info.known = 1'b1;
      info.fid   = FID_SIZE;
      case (tag)
         TAG_SIZE:     info.fid = FID_SIZE;
         TAG_DESC:     info.fid = FID_DESC;
         TAG_FILE_ID:  info.fid = FID_FILE_ID;
         TAG_APP_ID:   info.fid = FID_APP_ID;
         TAG_SHORT_ID: info.fid = FID_SHORT_ID;
         TAG_LIFE:     info.fid = FID_LIFE;
         TAG_SEC:      info.fid = FID_SEC;
         TAG_SEC_ENV:  info.fid = FID_SEC_ENV;
         default:      info.known = 1'b0;
      endcase
      return info;
   endfunction

endpackage

// File: rtl/fcp_if.sv
// FCP template parser: request (command byte) and response channel interfaces.
// Depends on nothing; payload widths follow the block's field list.
interface fcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface fcp_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [2:0] field_id;
   logic [3:0] byte_index;
   logic [7:0] value_byte;
   logic       status;
   logic       end_of_run;

   modport source (output valid, output kind, output field_id, output byte_index,
                   output value_byte, output status, output end_of_run, input ready);
   modport sink   (input valid, input kind, input field_id, input byte_index,
                   input value_byte, input status, input end_of_run, output ready);
endinterface

// File: rtl/fcp_front.sv
// FCP template parser front end: takes command bytes, runs the TLV parse
// state and pushes one queue entry per byte that yields results. Uses fcp_pkg, fcp_if.
module fcp_front (
   input  logic                   clock,
   input  logic                   reset,
   fcp_req_if.sink                req,
   input  logic                   q_space,
   output logic                   q_push,
   output fcp_pkg::fcp_entry_type q_entry
);

   logic [2:0] phase_ff, phase_in;
   logic [2:0] field_ff, field_in;
   logic [4:0] left_ff, left_in;
   logic [3:0] pos_ff, pos_in;
   logic       err_ff, err_in;

   logic                      accept;
   logic                      emit_val;
   logic [4:0]                left_dec;
   logic [4:0]                limit;
   logic                      len_ok;
   fcp_pkg::fcp_tag_info_type info;

   assign req.ready = q_space;
   assign accept    = req.valid && q_space;

   assign info     = fcp_pkg::tag_lookup(req.data_byte);
   assign limit    = fcp_pkg::FIELD_LIMIT[field_ff];
   assign len_ok   = fcp_pkg::FIELD_EXACT[field_ff] ? (req.data_byte == {3'b000, limit})
                                                    : (req.data_byte <= {3'b000, limit});
   assign left_dec = left_ff - 5'd1;

   always_comb begin
      phase_in = phase_ff;
      field_in = field_ff;
      left_in  = left_ff;
      pos_in   = pos_ff;
      err_in   = err_ff;
      emit_val = 1'b0;
      if (!err_ff) begin
         case (phase_ff)
            fcp_pkg::PH_OUTER_TAG: begin
               if (req.data_byte == fcp_pkg::TEMPLATE_TAG) phase_in = fcp_pkg::PH_OUTER_LEN;
               else err_in = 1'b1;
            end
            // template length is not checked
            fcp_pkg::PH_OUTER_LEN: phase_in = fcp_pkg::PH_TAG;
            fcp_pkg::PH_TAG: begin
               if (info.known) begin
                  field_in = info.fid;
                  phase_in = fcp_pkg::PH_LEN;
               end else begin
                  err_in = 1'b1;
               end
            end
            fcp_pkg::PH_LEN: begin
               if (!len_ok) begin
                  err_in = 1'b1;
               end else if (req.data_byte == 8'd0) begin
                  phase_in = fcp_pkg::PH_TAG;
               end else begin
                  left_in  = req.data_byte[4:0];  // length is at most 16 here
                  pos_in   = 4'd0;
                  phase_in = fcp_pkg::PH_VALUE;
               end
            end
            fcp_pkg::PH_VALUE: begin
               emit_val = 1'b1;
               pos_in   = pos_ff + 4'd1;
               left_in  = left_dec;
               if (left_dec == 5'd0) phase_in = fcp_pkg::PH_TAG;
            end
            default: err_in = 1'b1;
         endcase
      end
   end

   always_comb begin
      q_entry.has_value  = emit_val;
      q_entry.field_id   = field_ff;
      q_entry.byte_index = pos_ff;
      q_entry.value_byte = req.data_byte;
      q_entry.has_status = req.last;
      q_entry.status     = (err_in || phase_in != fcp_pkg::PH_TAG) ? fcp_pkg::ST_BAD_DATA
                                                                   : fcp_pkg::ST_OK;
   end

   assign q_push = accept && (emit_val || req.last);

   always_ff @(posedge clock) begin
      if (reset || (accept && req.last)) begin
         phase_ff <= fcp_pkg::PH_OUTER_TAG;
         field_ff <= 3'd0;
         left_ff  <= 5'd0;
         pos_ff   <= 4'd0;
         err_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         field_ff <= field_in;
         left_ff  <= left_in;
         pos_ff   <= pos_in;
         err_ff   <= err_in;
      end
   end

endmodule

// File: rtl/fcp_queue.sv
// FCP template parser: small FIFO of parsed entries between front and back end.
// Uses fcp_pkg.
module fcp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fcp_pkg::fcp_entry_type push_entry,
   output logic                   space,
   input  logic                   pop,
   output logic                   avail,
   output fcp_pkg::fcp_entry_type head
);

   fcp_pkg::fcp_entry_type slot_ff [fcp_pkg::QDepth];

   logic [fcp_pkg::QAw-1:0] wr_ff, wr_in;
   logic [fcp_pkg::QAw-1:0] rd_ff, rd_in;
   logic [fcp_pkg::QAw:0]   cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign space   = (cnt_ff != fcp_pkg::QDepth[fcp_pkg::QAw:0]);
   assign avail   = (cnt_ff != '0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && space;
   assign do_pop  = pop && avail;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

// File: rtl/fcp_back.sv
// FCP template parser back end: expands queue entries into value and status
// transactions through a registered output stage. Uses fcp_pkg, fcp_if.
module fcp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   avail,
   input  fcp_pkg::fcp_entry_type head,
   output logic                   pop,
   fcp_rsp_if.source              rsp
);

   logic                     valid_ff, valid_in;
   logic                     vdone_ff, vdone_in;
   fcp_pkg::fcp_result_type  res_ff, res_in;
   logic                     load;

   // output register can take a new result when empty or being drained
   assign load = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      vdone_in = vdone_ff;
      res_in   = res_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = avail;
         if (avail) begin
            if (head.has_value && !vdone_ff) begin
               res_in.kind       = fcp_pkg::KIND_VALUE;
               res_in.field_id   = head.field_id;
               res_in.byte_index = head.byte_index;
               res_in.value_byte = head.value_byte;
               res_in.status     = fcp_pkg::ST_OK;
               res_in.end_of_run = 1'b0;
               if (head.has_status) vdone_in = 1'b1;
               else pop = 1'b1;
            end else begin
               res_in.kind       = fcp_pkg::KIND_STATUS;
               res_in.field_id   = 3'd0;
               res_in.byte_index = 4'd0;
               res_in.value_byte = 8'd0;
               res_in.status     = head.status;
               res_in.end_of_run = 1'b1;
               vdone_in          = 1'b0;
               pop               = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         vdone_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         vdone_ff <= vdone_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp.valid      = valid_ff;
   assign rsp.kind       = res_ff.kind;
   assign rsp.field_id   = res_ff.field_id;
   assign rsp.byte_index = res_ff.byte_index;
   assign rsp.value_byte = res_ff.value_byte;
   assign rsp.status     = res_ff.status;
   assign rsp.end_of_run = res_ff.end_of_run;

endmodule

// File: rtl/fcp_tlv_parser.sv
// Channel   Dir  Payload                                                 Moves
// req       in   data_byte[7:0], last                                    one command byte
// rsp       out  kind, field_id[2:0], byte_index[3:0], value_byte[7:0],  value byte or
//                status, end_of_run                                      final status
//
// One command byte is taken per cycle while the queue has space; the parse state updates
// in that cycle. A byte yields at most two results; the output register sends one per
// cycle while rsp is ready, so a last byte inside a value needs two transfers, absorbed
// by the 4-entry queue. Results reach rsp through the queue and the output register.
// Synchronous reset returns the parser to expecting the template tag.
// req stalls only when the queue is full; rsp stalls hold the output register.
// Uses fcp_pkg, fcp_if, fcp_front, fcp_queue, fcp_back.
module fcp_tlv_parser (
   input  logic      clock,
   input  logic      reset,
   fcp_req_if.sink   req,
   fcp_rsp_if.source rsp
);

   logic                   q_space, q_push, q_avail, q_pop;
   fcp_pkg::fcp_entry_type q_entry, q_head;

   fcp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_space (q_space),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   fcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .space      (q_space),
      .pop        (q_pop),
      .avail      (q_avail),
      .head       (q_head)
   );

   fcp_back u_back (
      .clock (clock),
      .reset (reset),
      .avail (q_avail),
      .head  (q_head),
      .pop   (q_pop),
      .rsp   (rsp)
   );

endmodule
